// File: design/sle_pkg.sv
// Shared types, constants and helpers for the sorted list engine.
// No dependencies; every other file in design/ uses this package.
`default_nettype none

package sle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CMD_W        = 2;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int S_TDATA_W    = 40;  // command + value, padded to 5 bytes
    localparam int M_TDATA_W    = 40;  // status + entry + count, padded to 5 bytes

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_START,
        S_INS_WALK,
        S_DEL_START,
        S_DEL_WALK,
        S_DUMP_START,
        S_DUMP_WALK,
        S_RESP_DONE,
        S_RESP_FULL,
        S_RESP_NOT_FOUND,
        S_RESP_EMPTY,
        S_RESP_DUMP_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_FILL,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_IDX_M2,
        RA_IDX_P1
    } rd_addr_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_VAL_AT_IDX,
        WR_RD_AT_IDX,
        WR_RD_AT_IDX_M1
    } wr_op_t;

    typedef enum logic [1:0] {
        FILL_HOLD,
        FILL_INC,
        FILL_DEC
    } fill_op_t;

    typedef enum logic [1:0] {
        FOUND_HOLD,
        FOUND_CLR,
        FOUND_UPD
    } found_op_t;

    typedef enum logic [1:0] {
        OUT_VAL,
        OUT_ZERO,
        OUT_RD
    } out_src_t;

    // controller -> datapath
    typedef struct packed {
        logic         load_val;
        idx_op_t      idx_op;
        logic         rd_en;
        rd_addr_sel_t rd_sel;
        wr_op_t       wr_op;
        fill_op_t     fill_op;
        found_op_t    found_op;
        logic         out_load;
        status_t      out_status;
        out_src_t     out_src;
        logic         out_last;
    } sle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fill_zero;
        logic fill_full;
        logic idx_zero;
        logic idx_one;
        logic idx_at_end;   // idx == fill - 1
        logic shift_up;     // read entry sorts at or above the value
        logic found;
        logic found_next;
        logic out_free;
    } sle_stat_t;

    // Flip the sign bit so that unsigned order equals signed order.
    function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
        order_key = {~v[VALUE_W-1], v[VALUE_W-2:0]};
    endfunction

endpackage

`default_nettype wire

// File: design/sle_datapath.sv
// Datapath: entry memory, fill count, walk index, value register, result register.
// Depends on sle_pkg; driven by sle_ctrl through sle_cmd_t.
`default_nettype none

module sle_datapath #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sle_pkg::sle_cmd_t               cmd,
    input  wire logic [sle_pkg::VALUE_W-1:0]     in_value,
    output sle_pkg::sle_stat_t                   stat,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [sle_pkg::STATUS_W-1:0]         out_status,
    output logic [sle_pkg::VALUE_W-1:0]          out_entry,
    output logic [sle_pkg::COUNT_W-1:0]          out_count,
    output logic                                 out_last
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int VW     = sle_pkg::VALUE_W;
    localparam int CW     = sle_pkg::COUNT_W;
    localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);
    localparam logic [FILL_W-1:0] ONE      = FILL_W'(1);
    localparam logic [FILL_W-1:0] TWO      = FILL_W'(2);

    logic [VW-1:0]     mem [CAPACITY];
    logic [VW-1:0]     rd_data_reg;
    logic [VW-1:0]     val_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              found_reg, found_next;

    logic                    out_valid_reg;
    logic [sle_pkg::STATUS_W-1:0] out_status_reg;
    logic [VW-1:0]           out_entry_reg;
    logic [CW-1:0]           out_count_reg;
    logic                    out_last_reg;

    logic [FILL_W-1:0] rd_addr_full;
    logic [FILL_W-1:0] wr_addr_full;
    logic [VW-1:0]     wr_data;
    logic              wr_en;
    logic              hit;
    logic              out_free;
    logic [CW+FILL_W-1:0] count_ext;

    // read address
    always_comb begin
        case (cmd.rd_sel)
            sle_pkg::RA_IDX:    rd_addr_full = idx_reg;
            sle_pkg::RA_IDX_M1: rd_addr_full = idx_reg - ONE;
            sle_pkg::RA_IDX_M2: rd_addr_full = idx_reg - TWO;
            sle_pkg::RA_IDX_P1: rd_addr_full = idx_reg + ONE;
            default:            rd_addr_full = idx_reg;
        endcase
    end

    // write port
    always_comb begin
        wr_en        = 1'b1;
        wr_addr_full = idx_reg;
        wr_data      = rd_data_reg;
        case (cmd.wr_op)
            sle_pkg::WR_NONE:         wr_en = 1'b0;
            sle_pkg::WR_VAL_AT_IDX:   wr_data = val_reg;
            sle_pkg::WR_RD_AT_IDX:    wr_data = rd_data_reg;
            sle_pkg::WR_RD_AT_IDX_M1: wr_addr_full = idx_reg - ONE;
            default:                  wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr_full[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr_full[ADDR_W-1:0]];
        end
        if (cmd.load_val) begin
            val_reg <= in_value;
        end
    end

    assign hit = (rd_data_reg == val_reg);

    always_comb begin
        case (cmd.fill_op)
            sle_pkg::FILL_INC: fill_next = fill_reg + ONE;
            sle_pkg::FILL_DEC: fill_next = fill_reg - ONE;
            default:           fill_next = fill_reg;
        endcase
        case (cmd.idx_op)
            sle_pkg::IDX_LOAD_FILL: idx_next = fill_reg;
            sle_pkg::IDX_ZERO:      idx_next = '0;
            sle_pkg::IDX_INC:       idx_next = idx_reg + ONE;
            sle_pkg::IDX_DEC:       idx_next = idx_reg - ONE;
            default:                idx_next = idx_reg;
        endcase
        case (cmd.found_op)
            sle_pkg::FOUND_CLR: found_next = 1'b0;
            sle_pkg::FOUND_UPD: found_next = found_reg | hit;
            default:            found_next = found_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    // result register; count is the fill after this command, modulo 32
    assign out_free  = !out_valid_reg || out_ready;
    assign count_ext = {{CW{1'b0}}, fill_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_count_reg  <= count_ext[CW-1:0];
            out_last_reg   <= cmd.out_last;
            case (cmd.out_src)
                sle_pkg::OUT_VAL:  out_entry_reg <= val_reg;
                sle_pkg::OUT_ZERO: out_entry_reg <= '0;
                sle_pkg::OUT_RD:   out_entry_reg <= rd_data_reg;
                default:           out_entry_reg <= val_reg;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_entry  = out_entry_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    always_comb begin
        stat.fill_zero  = (fill_reg == '0);
        stat.fill_full  = (fill_reg >= CAP_FILL);
        stat.idx_zero   = (idx_reg == '0);
        stat.idx_one    = (idx_reg == ONE);
        stat.idx_at_end = (idx_reg == fill_reg - ONE);
        stat.shift_up   = (sle_pkg::order_key(rd_data_reg) >= sle_pkg::order_key(val_reg));
        stat.found      = found_reg;
        stat.found_next = found_reg | hit;
        stat.out_free   = out_free;
    end

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_FILL)
        else $error("fill exceeds capacity");

    a_inc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_op == sle_pkg::FILL_INC |-> fill_reg < CAP_FILL)
        else $error("insert into full store");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten while held");

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> wr_addr_full < CAP_FILL)
        else $error("entry write out of range");

endmodule

`default_nettype wire

// File: design/sle_ctrl.sv
// Controller: sequences insert, delete and dump walks over the entry memory.
// Depends on sle_pkg; drives sle_datapath through sle_cmd_t.
`default_nettype none

module sle_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sle_pkg::CMD_W-1:0]   in_command,
    input  wire sle_pkg::sle_stat_t          stat,
    output sle_pkg::sle_cmd_t                cmd
);

    sle_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sle_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sle_pkg::S_IDLE: begin
                if (in_valid) begin
                    case (in_command)
                        sle_pkg::CMD_INSERT: state_next = stat.fill_full ?
                            sle_pkg::S_RESP_FULL : sle_pkg::S_INS_START;
                        sle_pkg::CMD_DELETE: state_next = stat.fill_zero ?
                            sle_pkg::S_RESP_EMPTY : sle_pkg::S_DEL_START;
                        sle_pkg::CMD_DUMP: state_next = stat.fill_zero ?
                            sle_pkg::S_RESP_DUMP_EMPTY : sle_pkg::S_DUMP_START;
                        default: state_next = sle_pkg::S_IDLE;
                    endcase
                end
            end
            sle_pkg::S_INS_START: begin
                state_next = stat.idx_zero ? sle_pkg::S_RESP_DONE : sle_pkg::S_INS_WALK;
            end
            sle_pkg::S_INS_WALK: begin
                if (!stat.shift_up) begin
                    state_next = sle_pkg::S_RESP_DONE;
                end else if (stat.idx_one) begin
                    state_next = sle_pkg::S_INS_START;
                end
            end
            sle_pkg::S_DEL_START: state_next = sle_pkg::S_DEL_WALK;
            sle_pkg::S_DEL_WALK: begin
                if (stat.idx_at_end) begin
                    state_next = stat.found_next ? sle_pkg::S_RESP_DONE
                                                 : sle_pkg::S_RESP_NOT_FOUND;
                end
            end
            sle_pkg::S_DUMP_START: state_next = sle_pkg::S_DUMP_WALK;
            sle_pkg::S_DUMP_WALK: begin
                if (stat.out_free && stat.idx_at_end) begin
                    state_next = sle_pkg::S_IDLE;
                end
            end
            sle_pkg::S_RESP_DONE,
            sle_pkg::S_RESP_FULL,
            sle_pkg::S_RESP_NOT_FOUND,
            sle_pkg::S_RESP_EMPTY,
            sle_pkg::S_RESP_DUMP_EMPTY: begin
                if (stat.out_free) begin
                    state_next = sle_pkg::S_IDLE;
                end
            end
            default: state_next = sle_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready       = 1'b0;
        cmd.load_val   = 1'b0;
        cmd.idx_op     = sle_pkg::IDX_HOLD;
        cmd.rd_en      = 1'b0;
        cmd.rd_sel     = sle_pkg::RA_IDX;
        cmd.wr_op      = sle_pkg::WR_NONE;
        cmd.fill_op    = sle_pkg::FILL_HOLD;
        cmd.found_op   = sle_pkg::FOUND_HOLD;
        cmd.out_load   = 1'b0;
        cmd.out_status = sle_pkg::STAT_DONE;
        cmd.out_src    = sle_pkg::OUT_VAL;
        cmd.out_last   = 1'b1;
        case (state_reg)
            sle_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_val = 1'b1;
                    cmd.found_op = sle_pkg::FOUND_CLR;
                    cmd.idx_op   = (in_command == sle_pkg::CMD_INSERT) ?
                                   sle_pkg::IDX_LOAD_FILL : sle_pkg::IDX_ZERO;
                end
            end
            sle_pkg::S_INS_START: begin
                if (stat.idx_zero) begin
                    cmd.wr_op   = sle_pkg::WR_VAL_AT_IDX;
                    cmd.fill_op = sle_pkg::FILL_INC;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sle_pkg::RA_IDX_M1;
                end
            end
            sle_pkg::S_INS_WALK: begin
                if (stat.shift_up) begin
                    cmd.wr_op  = sle_pkg::WR_RD_AT_IDX;
                    cmd.idx_op = sle_pkg::IDX_DEC;
                    if (!stat.idx_one) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sle_pkg::RA_IDX_M2;
                    end
                end else begin
                    cmd.wr_op   = sle_pkg::WR_VAL_AT_IDX;
                    cmd.fill_op = sle_pkg::FILL_INC;
                end
            end
            sle_pkg::S_DEL_START,
            sle_pkg::S_DUMP_START: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sle_pkg::RA_IDX;
            end
            sle_pkg::S_DEL_WALK: begin
                if (stat.found) begin
                    cmd.wr_op = sle_pkg::WR_RD_AT_IDX_M1;
                end
                if (stat.idx_at_end) begin
                    if (stat.found_next) begin
                        cmd.fill_op = sle_pkg::FILL_DEC;
                    end
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = sle_pkg::RA_IDX_P1;
                    cmd.idx_op   = sle_pkg::IDX_INC;
                    cmd.found_op = sle_pkg::FOUND_UPD;
                end
            end
            sle_pkg::S_DUMP_WALK: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = sle_pkg::OUT_RD;
                    cmd.out_last = stat.idx_at_end;
                    if (!stat.idx_at_end) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = sle_pkg::RA_IDX_P1;
                        cmd.idx_op = sle_pkg::IDX_INC;
                    end
                end
            end
            sle_pkg::S_RESP_DONE: begin
                cmd.out_load = stat.out_free;
            end
            sle_pkg::S_RESP_FULL: begin
                cmd.out_load   = stat.out_free;
                cmd.out_status = sle_pkg::STAT_FULL;
            end
            sle_pkg::S_RESP_NOT_FOUND: begin
                cmd.out_load   = stat.out_free;
                cmd.out_status = sle_pkg::STAT_NOT_FOUND;
            end
            sle_pkg::S_RESP_EMPTY: begin
                cmd.out_load   = stat.out_free;
                cmd.out_status = sle_pkg::STAT_EMPTY;
            end
            sle_pkg::S_RESP_DUMP_EMPTY: begin
                cmd.out_load   = stat.out_free;
                cmd.out_status = sle_pkg::STAT_EMPTY;
                cmd.out_src    = sle_pkg::OUT_ZERO;
            end
            default: begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    a_walk_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != sle_pkg::S_IDLE |-> !in_ready)
        else $error("item taken while a command is in progress");

    a_ins_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sle_pkg::S_IDLE && in_valid
         && in_command == sle_pkg::CMD_INSERT && stat.fill_full)
        |=> state_reg == sle_pkg::S_RESP_FULL)
        else $error("insert into full store not dropped");

    a_dump_last_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_src == sle_pkg::OUT_RD && cmd.out_last)
        |=> state_reg == sle_pkg::S_IDLE)
        else $error("dump continued past its last entry");

endmodule

`default_nettype wire

// File: design/sorted_list_engine_unit.sv
// Top level of the sorted list engine: stream ports, controller and datapath.
// Depends on sle_pkg, sle_ctrl and sle_datapath.
//
// Usage:
//   Input channel s_*: one item is a command (insert, delete one copy, dump)
//   with a signed 32-bit value. Result channel m_*: status, entry, count;
//   m_tlast marks the final result of a command. Insert and delete give one
//   result each; dump gives one result per held entry, smallest first, or a
//   single "store empty" result. Code 3 is ignored and gives no result.
// Timing:
//   Entries live in a single-port-write, single-port-read memory with a
//   registered read, so every walk moves one entry per cycle (a dump only
//   while m_tready is high). Insert: a walk/shift from the end down to the
//   insert position (a direct write on an empty store), then the result state.
//   Delete: a scan/shift over all entries, then the result state.
//   Dump: a setup state, then one entry per cycle while m_tready is high.
//   The longest commands are an insert at the front of CAPACITY - 1 entries
//   and a delete over CAPACITY entries.
//   s_tready is high only between commands; the next item is taken while
//   the previous result still waits in the output register.
// Reset (aresetn low, synchronous): store empty, output register empty.
// Stall: a low m_tready holds the result register; a dump pauses its walk.
`default_nettype none

module sorted_list_engine_unit #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sle_pkg::S_TDATA_W-1:0]     s_tdata,   // command[1:0], value[33:2]
    // results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sle_pkg::M_TDATA_W-1:0]          m_tdata,   // status[1:0], entry[33:2],
                                                              // count[38:34]
    output logic                                   m_tlast
);

    localparam int CMD_W    = sle_pkg::CMD_W;
    localparam int VW       = sle_pkg::VALUE_W;
    localparam int SW       = sle_pkg::STATUS_W;
    localparam int CW       = sle_pkg::COUNT_W;
    localparam int M_USED_W = SW + VW + CW;

    sle_pkg::sle_cmd_t  cmd;
    sle_pkg::sle_stat_t stat;

    logic [CMD_W-1:0] in_command;
    logic [VW-1:0]    in_value;
    logic [SW-1:0]    out_status;
    logic [VW-1:0]    out_entry;
    logic [CW-1:0]    out_count;

    // unpack input item; padding bits are ignored
    assign in_command = s_tdata[CMD_W-1:0];
    assign in_value   = s_tdata[CMD_W+VW-1:CMD_W];

    sle_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (in_command),
        .stat       (stat),
        .cmd        (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_value   (in_value),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_entry  (out_entry),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    // pack result item, zero padding on top
    assign m_tdata = {{(sle_pkg::M_TDATA_W - M_USED_W){1'b0}}, out_count, out_entry, out_status};

endmodule

`default_nettype wire
